FILE: design/iad_pkg.sv
// shared types, constants and step tables for the adpcm nibble decoder
package iad_pkg;

  localparam int MAX_STEP_INDEX = 88;
  localparam int IDX_W          = 7;
  localparam int STEP_W         = 15;
  localparam int PCM_W          = 16;
  localparam int CODE_W         = 4;
  localparam int CFG_ADDR_W     = 3;

  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sh7fff;
  localparam logic signed [PCM_W-1:0] PCM_MIN = 16'sh8000;

  // register word indexes
  localparam logic REG_STEREO_MODE = 1'b0;

  typedef struct packed {
    logic signed [PCM_W-1:0] pred;
    logic [IDX_W-1:0]        idx;
  } chan_state_t;

  typedef struct packed {
    logic load;
    logic sel_lo;
    logic channel;
    logic last_of_block;
  } merge_ctl_t;

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    begin
      case (mag)
        3'd4:    adj = 5'sd2;
        3'd5:    adj = 5'sd4;
        3'd6:    adj = 5'sd6;
        3'd7:    adj = 5'sd8;
        default: adj = -5'sd1;
      endcase
      return adj;
    end
  endfunction

  function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] i);
    logic [STEP_W-1:0] s;
    begin
      case (i)
        7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
        7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
        7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
        7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
        7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
        7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
        7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
        7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
        7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
        7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
        7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
        7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
        7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
        7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
        7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
        7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
        7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
        7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
        7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
        7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
        7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
        7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
        7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
        7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
        7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
        7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
        7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
        7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
        7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
        7'd87: s = 15'd29794;
        default: s = 15'd32767;
      endcase
      return s;
    end
  endfunction

endpackage

FILE: design/iad_lane.sv
// one nibble decode lane: step lookup, difference, saturating add, index update
module iad_lane (
  input  logic [iad_pkg::CODE_W-1:0] code,
  input  iad_pkg::chan_state_t       st_in,
  output iad_pkg::chan_state_t       st_out
);

  logic [iad_pkg::IDX_W-1:0]   cur;
  logic [iad_pkg::STEP_W-1:0]  step;
  logic signed [8:0]           ni;
  logic [16:0]                 diff;
  logic signed [17:0]          sum;

  always_comb begin
    cur = (st_in.idx > iad_pkg::IDX_W'(iad_pkg::MAX_STEP_INDEX)) ?
          iad_pkg::IDX_W'(iad_pkg::MAX_STEP_INDEX) : st_in.idx;
    step = iad_pkg::step_size(cur);

    ni = $signed({2'b00, cur}) + 9'(iad_pkg::index_adjust(code[2:0]));
    if (ni < 9'sd0) begin
      st_out.idx = '0;
    end else if (ni > 9'(iad_pkg::MAX_STEP_INDEX)) begin
      st_out.idx = iad_pkg::IDX_W'(iad_pkg::MAX_STEP_INDEX);
    end else begin
      st_out.idx = ni[iad_pkg::IDX_W-1:0];
    end

    diff = 17'(step >> 3);
    if (code[2]) begin
      diff = diff + 17'(step);
    end
    if (code[1]) begin
      diff = diff + 17'(step >> 1);
    end
    if (code[0]) begin
      diff = diff + 17'(step >> 2);
    end

    if (code[3]) begin
      sum = 18'(st_in.pred) - $signed({1'b0, diff});
    end else begin
      sum = 18'(st_in.pred) + $signed({1'b0, diff});
    end

    if (sum > 18'(iad_pkg::PCM_MAX)) begin
      st_out.pred = iad_pkg::PCM_MAX;
    end else if (sum < 18'(iad_pkg::PCM_MIN)) begin
      st_out.pred = iad_pkg::PCM_MIN;
    end else begin
      st_out.pred = sum[iad_pkg::PCM_W-1:0];
    end
  end

endmodule

FILE: design/iad_merge.sv
// merging stage: picks the active lane and holds the result beat for the output
module iad_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  iad_pkg::merge_ctl_t            ctl,
  input  logic signed [iad_pkg::PCM_W-1:0] hi_sample,
  input  logic signed [iad_pkg::PCM_W-1:0] lo_sample,
  output logic                           can_load,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // pcm_sample
  output logic [1:0]                     out_tuser,  // channel, last_of_pair
  output logic                           out_tlast
);

  logic                            valid_r, valid_nxt;
  logic signed [iad_pkg::PCM_W-1:0] sample_r, sample_nxt;
  logic                            chan_r, chan_nxt;
  logic                            pair_r, pair_nxt;
  logic                            last_r, last_nxt;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt  = valid_r;
    sample_nxt = sample_r;
    chan_nxt   = chan_r;
    pair_nxt   = pair_r;
    last_nxt   = last_r;
    if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (ctl.load) begin
      valid_nxt  = 1'b1;
      sample_nxt = ctl.sel_lo ? lo_sample : hi_sample;
      chan_nxt   = ctl.channel;
      pair_nxt   = ctl.sel_lo;
      last_nxt   = ctl.last_of_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    sample_r <= sample_nxt;
    chan_r   <= chan_nxt;
    pair_r   <= pair_nxt;
    last_r   <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = sample_r;
  assign out_tuser  = {pair_r, chan_r};
  assign out_tlast  = last_r;

endmodule

FILE: design/ima_adpcm_nibble_decoder_top.sv
// Top level of the IMA 4-bit ADPCM nibble decoder. Each input beat carries one code
// byte and gives two output beats, high nibble first. A byte is held in an input
// register and decoded in two steps, the high nibble in u_lane_hi and the low nibble
// in u_lane_lo, so the block sustains one sample per cycle while out_tready holds and
// bytes arrive. In mono the low nibble uses the left state that the high nibble has
// just written; in stereo it uses the right state. A new byte is taken in the same
// cycle that the previous byte's low nibble is issued.
module ima_adpcm_nibble_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // code_byte
  input  logic                           in_tuser,   // start_of_clip
  input  logic                           in_tlast,   // end_of_block
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // pcm_sample
  output logic [1:0]                     out_tuser,  // channel, last_of_pair
  output logic                           out_tlast,  // last_of_block
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [iad_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  iad_pkg::chan_state_t left_r, left_nxt;
  iad_pkg::chan_state_t right_r, right_nxt;
  iad_pkg::chan_state_t hi_in, hi_out, lo_in, lo_out;
  iad_pkg::merge_ctl_t  mctl;

  logic       stereo_r, stereo_nxt;
  logic       hold_valid_r, hold_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       start_r, start_nxt;
  logic       eob_r, eob_nxt;
  logic       phase_r, phase_nxt;
  logic       can_load, fire, in_beat, cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == iad_pkg::REG_STEREO_MODE);
  assign cfg_prdata = (cfg_paddr[2] == iad_pkg::REG_STEREO_MODE) ?
                      {31'b0, stereo_r} : 32'b0;
  assign stereo_nxt = cfg_wr ? cfg_pwdata[0] : stereo_r;

  assign fire      = hold_valid_r && can_load;
  assign in_tready = !hold_valid_r || (fire && phase_r);
  assign in_beat   = in_tvalid && in_tready;

  // lane inputs, start of clip clears the state seen by the high nibble
  assign hi_in = start_r ? '0 : left_r;
  assign lo_in = stereo_r ? right_r : left_r;

  iad_lane u_lane_hi (
    .code   (byte_r[7:4]),
    .st_in  (hi_in),
    .st_out (hi_out)
  );

  iad_lane u_lane_lo (
    .code   (byte_r[3:0]),
    .st_in  (lo_in),
    .st_out (lo_out)
  );

  always_comb begin
    mctl.load          = fire;
    mctl.sel_lo        = phase_r;
    mctl.channel       = phase_r && stereo_r;
    mctl.last_of_block = phase_r && eob_r;
  end

  always_comb begin
    left_nxt       = left_r;
    right_nxt      = right_r;
    phase_nxt      = phase_r;
    hold_valid_nxt = hold_valid_r;
    byte_nxt       = byte_r;
    start_nxt      = start_r;
    eob_nxt        = eob_r;
    if (fire) begin
      if (!phase_r) begin
        left_nxt  = hi_out;
        phase_nxt = 1'b1;
        if (start_r) begin
          right_nxt = '0;
        end
      end else begin
        if (stereo_r) begin
          right_nxt = lo_out;
        end else begin
          left_nxt = lo_out;
        end
        phase_nxt      = 1'b0;
        hold_valid_nxt = 1'b0;
      end
    end
    if (in_beat) begin
      hold_valid_nxt = 1'b1;
      byte_nxt       = in_tdata;
      start_nxt      = in_tuser;
      eob_nxt        = in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      right_r      <= '0;
      stereo_r     <= 1'b0;
      hold_valid_r <= 1'b0;
      phase_r      <= 1'b0;
    end else begin
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      stereo_r     <= stereo_nxt;
      hold_valid_r <= hold_valid_nxt;
      phase_r      <= phase_nxt;
    end
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
    eob_r   <= eob_nxt;
  end

  iad_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mctl),
    .hi_sample  (hi_out.pred),
    .lo_sample  (lo_out.pred),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
